/* sv/vsa_pkg.sv */
// ----------------------------------------------------------------------------
// vsa_pkg
// Shared types, constants and crc helper for the video transmitter commander
// ----------------------------------------------------------------------------
package vsa_pkg;

    // frame bytes
    localparam logic [7:0] FRAME_PAD   = 8'h00;
    localparam logic [7:0] FRAME_SYNC1 = 8'hAA;
    localparam logic [7:0] FRAME_SYNC2 = 8'h55;
    localparam logic [7:0] FRAME_LEN   = 8'h01;
    localparam logic [7:0] CMD_CHANNEL = 8'h07;
    localparam logic [7:0] CMD_POWER   = 8'h05;
    localparam logic [7:0] CRC_POLY    = 8'hD5;

    // byte positions within a frame
    localparam logic [2:0] POS_PAD   = 3'd0;
    localparam logic [2:0] POS_SYNC1 = 3'd1;
    localparam logic [2:0] POS_SYNC2 = 3'd2;
    localparam logic [2:0] POS_CMD   = 3'd3;
    localparam logic [2:0] POS_LEN   = 3'd4;
    localparam logic [2:0] POS_CODE  = 3'd5;
    localparam logic [2:0] POS_CRC   = 3'd6;

    // register indexes
    localparam logic [1:0] REG_BAND      = 2'd0;
    localparam logic [1:0] REG_CHANNEL   = 2'd1;
    localparam logic [1:0] REG_POWER     = 2'd2;
    localparam logic [1:0] REG_LOW_POWER = 2'd3;

    localparam int ADDR_W = 4;

    typedef struct packed {
        logic [3:0] band;
        logic [3:0] channel;
        logic [7:0] power_level;
        logic       low_power;
    } vsa_cfg_t;

    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] code;
        logic       active;
    } vsa_frame_t;

    // one byte of crc8 dvb-s2, msb first
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* sv/vsa_front.sv */
// ----------------------------------------------------------------------------
// vsa_front
// Takes timer ticks, runs the command sequencer and queues frame requests
// ----------------------------------------------------------------------------
module vsa_front
    import vsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick_valid,
    output logic       tick_ready,
    input  logic       period_elapsed,
    input  logic       armed_now,
    input  vsa_cfg_t   cfg,
    input  logic       queue_full,
    output logic       push,
    output vsa_frame_t push_frame
);

    localparam logic [1:0] SEQ_INIT        = 2'd0;
    localparam logic [1:0] SEQ_SET_CHANNEL = 2'd1;
    localparam logic [1:0] SEQ_SET_POWER   = 2'd2;
    localparam logic [1:0] SEQ_IDLE        = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       armed_seen_reg, armed_seen_next;
    logic       active_reg, active_next;
    logic       take;
    logic [4:0] band_m1;
    logic [7:0] chan_m1;
    logic [7:0] chan_code;
    logic [7:0] power_code;

    assign tick_ready = !queue_full;
    assign take       = tick_valid && tick_ready && period_elapsed;

    // codes wrap modulo 256
    assign band_m1    = {1'b0, cfg.band} - 5'd1;
    assign chan_m1    = {4'd0, cfg.channel} - 8'd1;
    assign chan_code  = {band_m1, 3'd0} + chan_m1;
    assign power_code = (!cfg.low_power || armed_now) ? (cfg.power_level - 8'd1) : 8'd0;

    always_comb
    begin
        state_next        = state_reg;
        armed_seen_next   = armed_seen_reg;
        active_next       = active_reg;
        push              = 1'b0;
        push_frame.cmd    = CMD_CHANNEL;
        push_frame.code   = chan_code;
        push_frame.active = active_reg;
        if (take)
        begin
            unique case (state_reg)
                SEQ_INIT:
                begin
                    state_next  = SEQ_SET_CHANNEL;
                    active_next = 1'b1;
                end
                SEQ_SET_CHANNEL:
                begin
                    state_next = SEQ_SET_POWER;
                    push       = 1'b1;
                end
                SEQ_SET_POWER:
                begin
                    state_next      = SEQ_IDLE;
                    push            = 1'b1;
                    push_frame.cmd  = CMD_POWER;
                    push_frame.code = power_code;
                end
                default:
                begin
                    if (armed_now != armed_seen_reg)
                    begin
                        armed_seen_next = !armed_seen_reg;
                        state_next      = SEQ_SET_POWER;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SEQ_INIT;
            armed_seen_reg <= 1'b0;
            active_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            armed_seen_reg <= armed_seen_next;
            active_reg     <= active_next;
        end
    end

endmodule

/* sv/vsa_fifo.sv */
// ----------------------------------------------------------------------------
// vsa_fifo
// Two-entry queue of frame requests between sequencer and byte sender
// ----------------------------------------------------------------------------
module vsa_fifo
    import vsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  vsa_frame_t push_frame,
    output logic       full,
    output logic       head_valid,
    output vsa_frame_t head_frame,
    input  logic       pop
);

    vsa_frame_t entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_frame = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_frame;
    end

endmodule

/* sv/vsa_back.sv */
// ----------------------------------------------------------------------------
// vsa_back
// Serialises queued frame requests into bytes with a running crc8
// ----------------------------------------------------------------------------
module vsa_back
    import vsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  vsa_frame_t head_frame,
    output logic       pop,
    output logic       byte_valid,
    input  logic       byte_ready,
    output logic [7:0] tx_byte,
    output logic       frame_last,
    output logic       vtx_active
);

    logic [2:0] pos_reg, pos_next;
    logic [7:0] crc_reg, crc_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       active_reg;
    logic       load;
    logic [7:0] cur_byte;

    assign load = head_valid && (!valid_reg || byte_ready);
    assign pop  = load && (pos_reg == POS_CRC);

    always_comb
    begin
        unique case (pos_reg)
            POS_PAD:   cur_byte = FRAME_PAD;
            POS_SYNC1: cur_byte = FRAME_SYNC1;
            POS_SYNC2: cur_byte = FRAME_SYNC2;
            POS_CMD:   cur_byte = head_frame.cmd;
            POS_LEN:   cur_byte = FRAME_LEN;
            POS_CODE:  cur_byte = head_frame.code;
            default:   cur_byte = crc_reg;
        endcase
    end

    // pad byte is outside the crc, so it restarts the sum
    assign crc_next = (pos_reg == POS_PAD) ? 8'd0 : crc_step(crc_reg, cur_byte);
    assign pos_next = (pos_reg == POS_CRC) ? POS_PAD : pos_reg + 3'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_PAD;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                pos_reg   <= pos_next;
                valid_reg <= 1'b1;
            end
            else if (byte_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            crc_reg    <= crc_next;
            byte_reg   <= cur_byte;
            last_reg   <= (pos_reg == POS_CRC);
            active_reg <= head_frame.active;
        end
    end

    assign byte_valid = valid_reg;
    assign tx_byte    = byte_reg;
    assign frame_last = last_reg;
    assign vtx_active = active_reg;

endmodule

/* sv/vtx_smartaudio_commander.sv */
// ----------------------------------------------------------------------------
// vtx_smartaudio_commander
// Control-frame generator for a serial video transmitter link
// ----------------------------------------------------------------------------
// Ticks come in on tick_valid/tick_ready with period_elapsed and armed_now.
// The first elapsed tick initialises and raises the active flag, the next
// sends a channel frame, the next a power frame; afterwards a change of the
// armed flag on an elapsed tick sends the power frame again on the next one.
// Each frame leaves on byte_valid/byte_ready as seven byte transfers:
// 00 AA 55 cmd 01 code crc, with frame_last on the crc byte.
// A tick is accepted whenever the two-entry frame queue has room; a frame
// request passes through the queue and then the sender's byte register.
// The byte sender moves one byte per cycle while a frame is queued and the
// receiver is ready, and the sender sets the sustained frame rate.
// When the receiver stalls, the shown byte holds and ticks are still taken
// until the queue is full. Reset empties the queue, returns the sequencer
// to initialisation and loads band 1, channel 1, power 1, low power off.
// Registers are written over the apb port at byte addresses 0, 4, 8, 12.
// ----------------------------------------------------------------------------
module vtx_smartaudio_commander
    import vsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              tick_valid,
    output logic              tick_ready,
    input  logic              period_elapsed,
    input  logic              armed_now,
    output logic              byte_valid,
    input  logic              byte_ready,
    output logic [7:0]        tx_byte,
    output logic              frame_last,
    output logic              vtx_active
);

    vsa_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;
    logic       queue_full;
    logic       push;
    vsa_frame_t push_frame;
    logic       head_valid;
    vsa_frame_t head_frame;
    logic       pop;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band        <= 4'd1;
            cfg_reg.channel     <= 4'd1;
            cfg_reg.power_level <= 8'd1;
            cfg_reg.low_power   <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_BAND:    cfg_reg.band        <= pwdata[3:0];
                REG_CHANNEL: cfg_reg.channel     <= pwdata[3:0];
                REG_POWER:   cfg_reg.power_level <= pwdata[7:0];
                default:     cfg_reg.low_power   <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_BAND:    prdata = {28'd0, cfg_reg.band};
            REG_CHANNEL: prdata = {28'd0, cfg_reg.channel};
            REG_POWER:   prdata = {24'd0, cfg_reg.power_level};
            default:     prdata = {31'd0, cfg_reg.low_power};
        endcase
    end

    vsa_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick_valid     (tick_valid),
        .tick_ready     (tick_ready),
        .period_elapsed (period_elapsed),
        .armed_now      (armed_now),
        .cfg            (cfg_reg),
        .queue_full     (queue_full),
        .push           (push),
        .push_frame     (push_frame)
    );

    vsa_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_frame (head_frame),
        .pop        (pop)
    );

    vsa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_frame (head_frame),
        .pop        (pop),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .tx_byte    (tx_byte),
        .frame_last (frame_last),
        .vtx_active (vtx_active)
    );

endmodule

/* sv/vsa_checker.sv */
// ----------------------------------------------------------------------------
// vsa_checker
// Port-level checks on the byte stream of the commander
// ----------------------------------------------------------------------------
module vsa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       byte_valid,
    input logic       byte_ready,
    input logic [7:0] tx_byte,
    input logic       frame_last,
    input logic       vtx_active
);

    // a stalled byte holds
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_ready |=> byte_valid && $stable(tx_byte) && $stable(frame_last))
        else $error("stalled byte changed");

    // frames only go out once initialisation has raised the active flag
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid |-> vtx_active)
        else $error("byte sent while inactive");

    // a frame that follows straight on starts with the pad byte
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready && frame_last |=> !byte_valid || (tx_byte == 8'h00 && !frame_last))
        else $error("frame did not start with pad byte");

endmodule

bind vtx_smartaudio_commander vsa_checker u_vsa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .tx_byte    (tx_byte),
    .frame_last (frame_last),
    .vtx_active (vtx_active)
);
